// ----- sv/mrqg_pkg.sv -----
// Shared types and constants for the mouse report quadrature generator.
package mrqg_pkg;

  // Request kinds carried in req_type
  localparam logic ReqLoad = 1'b0;
  localparam logic ReqTick = 1'b1;

  // Status byte bit positions
  localparam int unsigned StLeftBit  = 0;
  localparam int unsigned StRightBit = 1;
  localparam int unsigned StXSignBit = 4;
  localparam int unsigned StYSignBit = 5;

  // Quadrature line bit positions
  localparam int unsigned QlHPulse = 0;
  localparam int unsigned QlHQuad  = 1;
  localparam int unsigned QlVPulse = 2;
  localparam int unsigned QlVQuad  = 3;

  // Direction bit positions
  localparam int unsigned DirYNeg = 0;
  localparam int unsigned DirXNeg = 1;

  localparam logic [15:0] PhaseTicksRst = 16'd10;

  typedef struct packed {
    logic       req_type;
    logic [7:0] status_byte;
    logic [7:0] x_byte;
    logic [7:0] y_byte;
  } mrqg_req_t;

  typedef struct packed {
    logic left_button_n;
    logic right_button_n;
    logic h_pulse;
    logic h_quad;
    logic v_pulse;
    logic v_quad;
    logic busy_res;
    logic report_dropped;
  } mrqg_res_t;

  typedef struct packed {
    logic [1:0]  button_lines;
    logic [3:0]  quad_lines;
    logic [7:0]  vert_steps_left;
    logic [7:0]  horiz_steps_left;
    logic [1:0]  direction_bits;
    logic [1:0]  phase_index;
    logic [15:0] dwell_count;
  } mrqg_state_t;

  localparam mrqg_state_t StateRst = '{
    button_lines:     2'b11,
    quad_lines:       4'b0000,
    vert_steps_left:  8'd0,
    horiz_steps_left: 8'd0,
    direction_bits:   2'b00,
    phase_index:      2'd0,
    dwell_count:      16'd0
  };

endpackage

// ----- sv/mrqg_step.sv -----
// Next-state and result logic for one request of the quadrature generator.
module mrqg_step (
  input  mrqg_pkg::mrqg_req_t   req_i,
  input  mrqg_pkg::mrqg_state_t state_i,
  input  logic [15:0]           phase_ticks_i,
  output mrqg_pkg::mrqg_state_t state_o,
  output mrqg_pkg::mrqg_res_t   res_o
);

  logic        busy;
  logic        vert;
  logic        neg;
  logic        first_is_pulse;
  logic [1:0]  pulse_bit;
  logic [1:0]  quad_bit;
  logic [1:0]  first_bit;
  logic [1:0]  second_bit;
  logic [15:0] dwell_inc;
  logic        phase_end;
  logic        dropped;
  logic        y_neg;
  logic        x_neg;
  mrqg_pkg::mrqg_state_t nxt;

  assign busy = (state_i.vert_steps_left != 8'd0) || (state_i.horiz_steps_left != 8'd0);

  // Which lines move in this step and in which order
  assign vert      = state_i.vert_steps_left != 8'd0;
  assign neg       = vert ? state_i.direction_bits[mrqg_pkg::DirYNeg]
                          : state_i.direction_bits[mrqg_pkg::DirXNeg];
  assign first_is_pulse = vert ? neg : !neg;
  assign pulse_bit  = vert ? 2'(mrqg_pkg::QlVPulse) : 2'(mrqg_pkg::QlHPulse);
  assign quad_bit   = vert ? 2'(mrqg_pkg::QlVQuad)  : 2'(mrqg_pkg::QlHQuad);
  assign first_bit  = first_is_pulse ? pulse_bit : quad_bit;
  assign second_bit = first_is_pulse ? quad_bit  : pulse_bit;

  // Dwell counter; a zero setting ends every phase after one tick
  assign dwell_inc = state_i.dwell_count + 16'd1;
  assign phase_end = (dwell_inc == 16'd0) || (dwell_inc >= phase_ticks_i);

  // Report fields, negative counts negated modulo 256
  assign y_neg = req_i.status_byte[mrqg_pkg::StYSignBit];
  assign x_neg = req_i.status_byte[mrqg_pkg::StXSignBit];

  always_comb begin
    nxt     = state_i;
    dropped = 1'b0;
    if (req_i.req_type == mrqg_pkg::ReqLoad) begin
      if (busy) begin
        dropped = 1'b1;
      end else begin
        nxt.button_lines = {!req_i.status_byte[mrqg_pkg::StRightBit],
                            !req_i.status_byte[mrqg_pkg::StLeftBit]};
        nxt.vert_steps_left  = y_neg ? (8'd0 - req_i.y_byte) : req_i.y_byte;
        nxt.horiz_steps_left = x_neg ? (8'd0 - req_i.x_byte) : req_i.x_byte;
        nxt.direction_bits   = {x_neg, y_neg};
        nxt.phase_index      = 2'd0;
        nxt.dwell_count      = 16'd0;
      end
    end else if (busy) begin
      // Line change on the first tick of a phase
      if (state_i.dwell_count == 16'd0) begin
        case (state_i.phase_index)
          2'd0:    nxt.quad_lines[first_bit]  = 1'b1;
          2'd1:    nxt.quad_lines[second_bit] = 1'b1;
          2'd2:    nxt.quad_lines[first_bit]  = 1'b0;
          default: nxt.quad_lines[second_bit] = 1'b0;
        endcase
      end
      if (phase_end) begin
        nxt.dwell_count = 16'd0;
        nxt.phase_index = state_i.phase_index + 2'd1;
        // Last phase of a step retires it from the current axis
        if (state_i.phase_index == 2'd3) begin
          if (vert) begin
            nxt.vert_steps_left = state_i.vert_steps_left - 8'd1;
          end else begin
            nxt.horiz_steps_left = state_i.horiz_steps_left - 8'd1;
          end
        end
      end else begin
        nxt.dwell_count = dwell_inc;
      end
    end
  end

  assign state_o = nxt;

  // Result shows the state after this request
  assign res_o.left_button_n  = nxt.button_lines[0];
  assign res_o.right_button_n = nxt.button_lines[1];
  assign res_o.h_pulse        = nxt.quad_lines[mrqg_pkg::QlHPulse];
  assign res_o.h_quad         = nxt.quad_lines[mrqg_pkg::QlHQuad];
  assign res_o.v_pulse        = nxt.quad_lines[mrqg_pkg::QlVPulse];
  assign res_o.v_quad         = nxt.quad_lines[mrqg_pkg::QlVQuad];
  assign res_o.busy_res       = (nxt.vert_steps_left != 8'd0) ||
                                (nxt.horiz_steps_left != 8'd0);
  assign res_o.report_dropped = dropped;

endmodule

// ----- sv/mouse_report_quadrature_generator.sv -----
// Top level of the mouse report quadrature generator.
// Takes one request per cycle while results are taken, either a PS/2 movement report or a
// time tick, and returns one result per request with the button, quadrature, busy and
// dropped-report levels as they stand after that request. Requests pass through an input
// register and then the state update into a result register; a request waits in the input
// register while the result register holds an untaken result. One request per cycle is
// sustained as long as results are taken, set by the combinational state update between
// the two registers. The phase_ticks register is written through the configuration
// channel, which is always ready.
module mouse_report_quadrature_generator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mrqg_pkg::mrqg_req_t in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mrqg_pkg::mrqg_res_t out_res_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [15:0]         cfg_data_i
);

  logic                  req_valid_q;
  mrqg_pkg::mrqg_req_t   req_q;
  logic                  out_valid_q;
  mrqg_pkg::mrqg_res_t   res_q;
  mrqg_pkg::mrqg_res_t   res_d;
  mrqg_pkg::mrqg_state_t state_q;
  mrqg_pkg::mrqg_state_t state_d;
  logic [15:0]           phase_ticks_q;
  logic                  advance;

  // A held request moves on when the result slot is free or being emptied
  assign advance     = req_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !req_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_req_i;
    end
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= mrqg_pkg::PhaseTicksRst;
    end else if (cfg_valid_i) begin
      phase_ticks_q <= cfg_data_i;
    end
  end

  mrqg_step u_step (
    .req_i         (req_q),
    .state_i       (state_q),
    .phase_ticks_i (phase_ticks_q),
    .state_o       (state_d),
    .res_o         (res_d)
  );

  // Generator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mrqg_pkg::StateRst;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

  // A dropped report can only come while steps are pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.report_dropped |-> res_q.busy_res)
    else $error("dropped report flagged while idle");

  // Idle generator sits at phase 0 with all quadrature lines low
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.vert_steps_left == 8'd0) && (state_q.horiz_steps_left == 8'd0)
    |-> (state_q.phase_index == 2'd0) && (state_q.dwell_count == 16'd0) &&
        (state_q.quad_lines == 4'b0000))
    else $error("idle generator left with phase or lines active");

  // State only moves when a request is processed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("generator state changed without a request");

  // A held request is not lost while the result slot is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_q && !advance |=> req_valid_q && $stable(req_q))
    else $error("held request lost during stall");

endmodule
